### design/rgbhsv_pkg.sv
// rgbhsv_pkg: widths, payload structs and the stage-zero record of the rgb to hsv converter
// no dependencies; imported by every module of the block
package rgbhsv_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 16;
   localparam int SAT_BITS     = 16;

   // quotient bits produced by each divider, one per pipeline stage
   localparam int QUOT_BITS = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
   // prep stage plus one stage per quotient bit
   localparam int STAGES    = QUOT_BITS + 1;

   // hue numerator in sixths of a turn is below 6 * delta
   localparam int HUE_NUM_BITS      = CHANNEL_BITS + 3;
   localparam int HUE_DIVIDEND_BITS = HUE_NUM_BITS + HUE_BITS;
   localparam int HUE_DIVISOR_BITS  = CHANNEL_BITS + 3;
   localparam int SAT_DIVIDEND_BITS = CHANNEL_BITS + SAT_BITS;
   localparam int SAT_DIVISOR_BITS  = CHANNEL_BITS;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [SAT_BITS-1:0]     saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic [HUE_DIVIDEND_BITS-1:0] hue_dividend;
      logic [HUE_DIVISOR_BITS-1:0]  hue_divisor;
      logic [SAT_DIVIDEND_BITS-1:0] sat_dividend;
      logic [SAT_DIVISOR_BITS-1:0]  sat_divisor;
      logic [CHANNEL_BITS-1:0]      bright;
   } prep_type;

endpackage

### design/rgbhsv_prep.sv
// rgbhsv_prep: first pipeline stage, max / min / delta, sextant numerator, divider operands
// depends on rgbhsv_pkg
module rgbhsv_prep (
   input  logic                  clock,
   input  logic                  enable,
   input  rgbhsv_pkg::pixel_type pixel,
   output rgbhsv_pkg::prep_type  prep
);
   import rgbhsv_pkg::*;

   localparam int NB = HUE_NUM_BITS;

   logic [CHANNEL_BITS-1:0] r, g, b, mx, mn, rg_min, delta;
   logic                    red_top, green_top;
   logic [NB-1:0]           d_ext, six_d, n;
   prep_type                prep_in, prep_ff;

   always_comb begin
      r = pixel.red;
      g = pixel.green;
      b = pixel.blue;
      // red wins ties, then green
      red_top   = (r >= g) && (r >= b);
      green_top = !red_top && (g >= b);
      mx        = red_top ? r : (green_top ? g : b);
      rg_min    = (r < g) ? r : g;
      mn        = (rg_min < b) ? rg_min : b;
      delta     = mx - mn;
      d_ext     = NB'(delta);
      six_d     = (d_ext << 2) + (d_ext << 1);

      if (red_top) begin
         if (g >= b) begin
            n = NB'(g - b);
         end else begin
            n = six_d - NB'(b - g);   // negative hue wraps one turn
         end
      end else if (green_top) begin
         n = (d_ext << 1) + NB'(b) - NB'(r);
      end else begin
         n = (d_ext << 2) + NB'(r) - NB'(g);
      end

      // a zero divisor becomes one with a zero dividend, giving a zero quotient
      prep_in.hue_dividend = {n, {HUE_BITS{1'b0}}};
      prep_in.hue_divisor  = (delta == '0) ? NB'(1) : six_d;
      prep_in.sat_dividend = {delta, {SAT_BITS{1'b0}}} - SAT_DIVIDEND_BITS'(delta);
      prep_in.sat_divisor  = (mx == '0) ? SAT_DIVISOR_BITS'(1) : mx;
      prep_in.bright       = mx;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule

### design/rgbhsv_div.sv
// rgbhsv_div: pipelined restoring divider, one quotient bit per register stage
// depends on rgbhsv_pkg for nothing but house style; operand widths come in as parameters
module rgbhsv_div #(
   parameter int DIVIDEND_BITS = 24,
   parameter int DIVISOR_BITS  = 8,
   parameter int QUOT_BITS     = 16
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic [QUOT_BITS-1:0]     quotient
);
   import rgbhsv_pkg::*;

   localparam int WIDE = (DIVIDEND_BITS > DIVISOR_BITS + QUOT_BITS) ?
                         DIVIDEND_BITS : DIVISOR_BITS + QUOT_BITS;

   logic [DIVIDEND_BITS-1:0] rem_src [QUOT_BITS];
   logic [DIVIDEND_BITS-1:0] rem_in  [QUOT_BITS];
   logic [DIVIDEND_BITS-1:0] rem_ff  [QUOT_BITS];
   logic [DIVISOR_BITS-1:0]  dvs_src [QUOT_BITS];
   logic [DIVISOR_BITS-1:0]  dvs_ff  [QUOT_BITS];
   logic [QUOT_BITS-1:0]     quo_src [QUOT_BITS];
   logic [QUOT_BITS-1:0]     quo_in  [QUOT_BITS];
   logic [QUOT_BITS-1:0]     quo_ff  [QUOT_BITS];

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
      logic [WIDE-1:0] rem_ext, sub_ext, diff;
      logic            take;

      if (j == 0) begin : g_first
         assign rem_src[j] = dividend;
         assign dvs_src[j] = divisor;
         assign quo_src[j] = '0;
      end else begin : g_next
         assign rem_src[j] = rem_ff[j-1];
         assign dvs_src[j] = dvs_ff[j-1];
         assign quo_src[j] = quo_ff[j-1];
      end

      // stage j decides quotient bit QUOT_BITS-1-j
      always_comb begin
         rem_ext   = WIDE'(rem_src[j]);
         sub_ext   = WIDE'(dvs_src[j]) << (QUOT_BITS - 1 - j);
         take      = rem_ext >= sub_ext;
         diff      = rem_ext - sub_ext;
         rem_in[j] = take ? diff[DIVIDEND_BITS-1:0] : rem_src[j];
         quo_in[j] = {quo_src[j][QUOT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in[j];
            dvs_ff[j] <= dvs_src[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[QUOT_BITS-1];

endmodule

### design/rgb_to_hsv.sv
// rgb_to_hsv: top level, valid chain, brightness delay line, output register and skid stage
// depends on rgbhsv_pkg, rgbhsv_prep and rgbhsv_div
// stages: prep stage, 16 divider stages, output register, one quotient bit a stage
// throughput: one pixel per cycle; under a response stall the pipeline keeps moving until a
//    transaction parks in the skid register, and the request side stalls from the next cycle
// reset: synchronous, clears every valid bit; data registers are not reset
module rgb_to_hsv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rgbhsv_pkg::pixel_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rgbhsv_pkg::hsv_type   rsp_data
);
   import rgbhsv_pkg::*;

   // one valid bit per pipeline stage, index 0 is the prep stage
   logic [STAGES-1:0]       valid_in, valid_ff;
   logic                    advance;

   prep_type                prep;
   logic [QUOT_BITS-1:0]    hue_quo, sat_quo;
   logic [CHANNEL_BITS-1:0] bright_ff [QUOT_BITS];

   // output register and the skid register behind it
   hsv_type                 last_data;
   hsv_type                 o_data_ff, s_data_ff;
   logic                    o_valid_in, o_valid_ff, s_valid_in, s_valid_ff;
   logic                    o_take, o_load_last, o_load_skid, s_load;

   // the whole pipeline moves as one while the skid register is empty
   assign advance   = !s_valid_ff;
   assign req_stall = s_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage zero: extremes, delta and divider operands
   rgbhsv_prep u_prep (
      .clock  (clock),
      .enable (advance),
      .pixel  (req_data),
      .prep   (prep)
   );

   // hue = numerator * 2^HUE_BITS / (6 * delta)
   rgbhsv_div #(
      .DIVIDEND_BITS (HUE_DIVIDEND_BITS),
      .DIVISOR_BITS  (HUE_DIVISOR_BITS),
      .QUOT_BITS     (QUOT_BITS)
   ) u_hue_div (
      .clock    (clock),
      .enable   (advance),
      .dividend (prep.hue_dividend),
      .divisor  (prep.hue_divisor),
      .quotient (hue_quo)
   );

   // saturation = delta * 65535 / max
   rgbhsv_div #(
      .DIVIDEND_BITS (SAT_DIVIDEND_BITS),
      .DIVISOR_BITS  (SAT_DIVISOR_BITS),
      .QUOT_BITS     (QUOT_BITS)
   ) u_sat_div (
      .clock    (clock),
      .enable   (advance),
      .dividend (prep.sat_dividend),
      .divisor  (prep.sat_divisor),
      .quotient (sat_quo)
   );

   // brightness rides alongside the divider stages
   always_ff @(posedge clock) begin
      if (advance) begin
         bright_ff[0] <= prep.bright;
         for (int k = 1; k < QUOT_BITS; k++) begin
            bright_ff[k] <= bright_ff[k-1];
         end
      end
   end

   always_comb begin
      last_data.hue        = hue_quo[HUE_BITS-1:0];
      last_data.saturation = sat_quo[SAT_BITS-1:0];
      last_data.brightness = bright_ff[QUOT_BITS-1];
   end

   // output side: the skid register catches the one transaction that leaves the
   // pipeline in the cycle the output register is found stalled
   assign o_take = o_valid_ff && !rsp_stall;

   always_comb begin
      o_valid_in  = o_valid_ff;
      s_valid_in  = s_valid_ff;
      o_load_last = 1'b0;
      o_load_skid = 1'b0;
      s_load      = 1'b0;
      if (s_valid_ff) begin
         if (o_take) begin
            o_load_skid = 1'b1;
            s_valid_in  = 1'b0;
         end
      end else if (!o_valid_ff || o_take) begin
         o_valid_in  = valid_ff[STAGES-1];
         o_load_last = valid_ff[STAGES-1];
      end else if (valid_ff[STAGES-1]) begin
         s_valid_in = 1'b1;
         s_load     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load_skid) begin
         o_data_ff <= s_data_ff;
      end else if (o_load_last) begin
         o_data_ff <= last_data;
      end
      if (s_load) begin
         s_data_ff <= last_data;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

   // the skid register only fills behind a waiting output register
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> o_valid_ff)
      else $error("skid register holds a transaction while the output register is empty");

   // a parked transaction keeps its data while the response side stalls
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && rsp_stall |=> s_valid_ff && $stable(s_data_ff))
      else $error("skid register lost or changed a parked transaction");

   // a nonzero hue needs a nonzero delta, hence a nonzero saturation
   a_hue_needs_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.hue != '0) |-> (rsp_data.saturation != '0))
      else $error("nonzero hue with zero saturation");

   // reset empties the pipeline and both output registers
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (valid_ff == '0) && !o_valid_ff && !s_valid_ff)
      else $error("valid bits survived reset");

endmodule

### tb/sv/rgb_to_hsv_checker.sv
`timescale 1ns / 1ps
// rgb_to_hsv_checker: watches both channels of the converter, predicts each hsv result and compares
// depends on rgbhsv_pkg for the payload structs and widths
module rgb_to_hsv_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  rgbhsv_pkg::pixel_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rgbhsv_pkg::hsv_type   rsp_data,
   output int                    failures,
   output int                    pending
);
   import rgbhsv_pkg::*;

   hsv_type expected_hsv[$];

   // fixed point conversion of one pixel; red, then green, then blue wins a tie for the maximum
   function automatic hsv_type convert_pixel(input pixel_type px);
      logic [CHANNEL_BITS-1:0]      peak;
      logic [CHANNEL_BITS-1:0]      floor_c;
      logic [CHANNEL_BITS-1:0]      spread;
      logic [HUE_DIVISOR_BITS-1:0]  spread6;
      logic [HUE_NUM_BITS-1:0]      sixths;
      logic [HUE_DIVIDEND_BITS-1:0] hue_num;
      logic [SAT_DIVIDEND_BITS-1:0] sat_num;
      hsv_type                      res;
      peak    = (px.red > px.green) ? px.red : px.green;
      peak    = (peak > px.blue) ? peak : px.blue;
      floor_c = (px.red < px.green) ? px.red : px.green;
      floor_c = (floor_c < px.blue) ? floor_c : px.blue;
      spread  = peak - floor_c;
      res     = '0;
      res.brightness = peak;
      if (spread != '0) begin
         spread6 = HUE_DIVISOR_BITS'(spread) * HUE_DIVISOR_BITS'(6);
         if (peak == px.red) begin
            // red sextant wraps by a full turn when green is below blue
            if (px.green >= px.blue) begin
               sixths = HUE_NUM_BITS'(px.green - px.blue);
            end else begin
               sixths = spread6 - HUE_NUM_BITS'(px.blue - px.green);
            end
         end else if (peak == px.green) begin
            sixths = (HUE_NUM_BITS'(spread) << 1) + HUE_NUM_BITS'(px.blue)
                     - HUE_NUM_BITS'(px.red);
         end else begin
            sixths = (HUE_NUM_BITS'(spread) << 2) + HUE_NUM_BITS'(px.red)
                     - HUE_NUM_BITS'(px.green);
         end
         hue_num = HUE_DIVIDEND_BITS'(sixths) << HUE_BITS;
         res.hue = HUE_BITS'(hue_num / HUE_DIVIDEND_BITS'(spread6));
      end
      if (peak != '0) begin
         sat_num        = SAT_DIVIDEND_BITS'(spread) * SAT_DIVIDEND_BITS'({SAT_BITS{1'b1}});
         res.saturation = SAT_BITS'(sat_num / SAT_DIVIDEND_BITS'(peak));
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      hsv_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_hsv.push_back(convert_pixel(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_hsv.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
               failures++;
            end else begin
               want = expected_hsv.pop_front();
               if (rsp_data.hue !== want.hue) begin
                  $display("%0t: hue expected %h got %h", $time, want.hue, rsp_data.hue);
                  failures++;
               end
               if (rsp_data.saturation !== want.saturation) begin
                  $display("%0t: saturation expected %h got %h", $time,
                           want.saturation, rsp_data.saturation);
                  failures++;
               end
               if (rsp_data.brightness !== want.brightness) begin
                  $display("%0t: brightness expected %h got %h", $time,
                           want.brightness, rsp_data.brightness);
                  failures++;
               end
            end
         end
         pending = expected_hsv.size();
      end
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: clock, reset and pixel stimulus for rgb_to_hsv, with random stalls on the response side
// depends on rgbhsv_pkg, rgb_to_hsv and rgb_to_hsv_checker
module testbench;
   import rgbhsv_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int SEGMENT      = 200;          // idling pattern is re-drawn every segment
   localparam int CALM_ITEMS   = 300;          // closing stretch with no idling at all
   localparam int SETTLE       = 40;           // margin for stray responses after the drain
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PIXEL_BITS   = $bits(pixel_type);

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   pixel_type req_data  = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   hsv_type   rsp_data;

   int          failures;
   int          pending;
   int unsigned cycle_count = 0;
   int          gap_odds    = 0;   // sender: 1 in gap_odds transactions is preceded by a gap
   int          stall_odds  = 0;   // receiver: 1 in stall_odds idle cycles starts a stall burst
   int          stall_left  = 0;

   rgb_to_hsv uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rgb_to_hsv_checker scoreboard (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // global watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("rgb_to_hsv: mismatch");
      $finish;
   end

   // response stalls come in bursts of random length; odds of zero means never stall
   always @(posedge clock) begin
      if (reset || stall_odds == 0) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(1, stall_odds) == 1) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   function automatic pixel_type pix(input logic [CHANNEL_BITS-1:0] r,
                                     input logic [CHANNEL_BITS-1:0] g,
                                     input logic [CHANNEL_BITS-1:0] b);
      pixel_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      return px;
   endfunction

   // mix of plain random pixels and shapes that hit greys, ties and the edges of the range
   function automatic pixel_type random_pixel();
      pixel_type               px;
      logic [CHANNEL_BITS-1:0] hi;
      logic [CHANNEL_BITS-1:0] lo;
      px = PIXEL_BITS'($urandom);
      hi = CHANNEL_BITS'($urandom);
      lo = CHANNEL_BITS'($urandom_range(0, hi));
      case ($urandom_range(0, 9))
         5: px = pix(hi, hi, hi);                       // grey, black and white included
         6: begin                                       // two channels tie for the maximum
            case ($urandom_range(0, 2))
               0:       px = pix(hi, hi, lo);
               1:       px = pix(hi, lo, hi);
               default: px = pix(lo, hi, hi);
            endcase
         end
         7: px = pix(CHANNEL_BITS'($urandom_range(0, 3)), CHANNEL_BITS'($urandom_range(0, 3)),
                     CHANNEL_BITS'($urandom_range(0, 3)));
         8: begin                                       // red and green at full scale or zero, blue at zero or hi
            px.red   = $urandom_range(0, 1) ? '1 : '0;
            px.green = $urandom_range(0, 1) ? '1 : '0;
            px.blue  = $urandom_range(0, 1) ? '0 : hi;
         end
         9: px = pix(hi + CHANNEL_BITS'($urandom_range(0, 2)),
                     hi + CHANNEL_BITS'($urandom_range(0, 2)),
                     hi + CHANNEL_BITS'($urandom_range(0, 2)));  // tiny delta, fine hue steps
         default: ;
      endcase
      return px;
   endfunction

   // one transaction on the request side, with an optional gap in front of it
   task automatic send_pixel(input pixel_type px);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the request side off until the pipeline has handed back everything
   task automatic wait_empty();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset      <= 1'b0;
      stall_odds <= 4;
      gap_odds    = 5;

      // directed corners: black, white, primaries, greys, ties and the red wrap
      send_pixel(pix(8'd0,   8'd0,   8'd0));
      send_pixel(pix(8'd255, 8'd255, 8'd255));
      send_pixel(pix(8'd128, 8'd128, 8'd128));
      send_pixel(pix(8'd1,   8'd1,   8'd1));
      send_pixel(pix(8'd255, 8'd0,   8'd0));
      send_pixel(pix(8'd0,   8'd255, 8'd0));
      send_pixel(pix(8'd0,   8'd0,   8'd255));
      send_pixel(pix(8'd255, 8'd255, 8'd0));
      send_pixel(pix(8'd255, 8'd0,   8'd255));
      send_pixel(pix(8'd0,   8'd255, 8'd255));
      send_pixel(pix(8'd255, 8'd0,   8'd1));
      send_pixel(pix(8'd255, 8'd1,   8'd0));
      send_pixel(pix(8'd255, 8'd254, 8'd255));
      send_pixel(pix(8'd1,   8'd0,   8'd0));
      send_pixel(pix(8'd0,   8'd1,   8'd0));
      send_pixel(pix(8'd0,   8'd0,   8'd1));
      send_pixel(pix(8'd254, 8'd255, 8'd255));
      send_pixel(pix(8'd255, 8'd255, 8'd254));
      send_pixel(pix(8'd170, 8'd85,  8'd0));
      send_pixel(pix(8'd0,   8'd85,  8'd170));
      send_pixel(pix(8'd85,  8'd0,   8'd170));
      send_pixel(pix(8'd200, 8'd100, 8'd150));

      // let the pipeline run dry once before the random part
      wait_empty();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
            gap_odds    = 0;
            stall_odds <= 0;
         end else if (i % SEGMENT == 0) begin
            // zero odds give stretches with no idling on that side
            gap_odds    = $urandom_range(0, 2) * 3;
            stall_odds <= $urandom_range(0, 2) * 3;
         end
         if (i == RANDOM_ITEMS / 2) begin
            wait_empty();
         end
         send_pixel(random_pixel());
      end

      // drain, then give any stray response time to show up
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("rgb_to_hsv: match");
      end else begin
         $display("rgb_to_hsv: mismatch");
      end
      $finish;
   end

endmodule

### files.f
design/rgbhsv_pkg.sv
design/rgbhsv_prep.sv
design/rgbhsv_div.sv
design/rgb_to_hsv.sv
tb/sv/rgb_to_hsv_checker.sv
tb/sv/testbench.sv
